// ----- hw/rtl/text_to_integer_parser_core_macros.svh -----
// Assertion macros shared by the text-to-integer parser RTL.
// Defining ASSERT_OFF compiles every assertion away.
`ifndef TEXT_TO_INTEGER_PARSER_CORE_MACROS_SVH
`define TEXT_TO_INTEGER_PARSER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked on every rising clock edge out of reset.
`define T2I_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("text_to_integer_parser_core: assertion failed");

// Next-cycle implication.
`define T2I_ASSERT_NXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("text_to_integer_parser_core: assertion failed");

`else

`define T2I_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define T2I_ASSERT_NXT(label, clk, rst_n, cond, prop)

`endif

`endif

// ----- hw/rtl/t2i_pkg.sv -----
// Package for the text-to-integer parser: character codes, limits and digit decoding.
// Has no dependencies; used by text_to_integer_parser_core.
package t2i_pkg;

    localparam int unsigned CharWidth  = 8;
    localparam int unsigned ValueWidth = 32;
    localparam int unsigned PosWidth   = 4;

    localparam logic [PosWidth-1:0] DigitLimitIndex    = 4'd10;
    localparam logic [PosWidth-1:0] HexFirstDigitIndex = 4'd2;

    localparam int unsigned KiloShift = 10;
    localparam int unsigned MegaShift = 20;
    localparam int unsigned HexShift  = 4;

    localparam logic [CharWidth-1:0] CH_NUL     = 8'h00;
    localparam logic [CharWidth-1:0] CH_ZERO    = 8'h30;
    localparam logic [CharWidth-1:0] CH_NINE    = 8'h39;
    localparam logic [CharWidth-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CharWidth-1:0] CH_UPPER_F = 8'h46;
    localparam logic [CharWidth-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CharWidth-1:0] CH_LOWER_F = 8'h66;
    localparam logic [CharWidth-1:0] CH_UPPER_K = 8'h4B;
    localparam logic [CharWidth-1:0] CH_LOWER_K = 8'h6B;
    localparam logic [CharWidth-1:0] CH_UPPER_M = 8'h4D;
    localparam logic [CharWidth-1:0] CH_LOWER_M = 8'h6D;
    localparam logic [CharWidth-1:0] CH_UPPER_X = 8'h58;
    localparam logic [CharWidth-1:0] CH_LOWER_X = 8'h78;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } digit_t;

    typedef struct packed {
        logic                  ok;
        logic [ValueWidth-1:0] value;
    } result_t;

    function automatic digit_t hex_digit(input logic [CharWidth-1:0] c);
        digit_t d;
        d.valid = 1'b1;
        d.value = 4'd0;
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            d.value = 4'(c - CH_ZERO);
        end else if (c inside {[CH_UPPER_A:CH_UPPER_F]}) begin
            d.value = 4'(c - CH_UPPER_A + 8'd10);
        end else if (c inside {[CH_LOWER_A:CH_LOWER_F]}) begin
            d.value = 4'(c - CH_LOWER_A + 8'd10);
        end else begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

    function automatic digit_t dec_digit(input logic [CharWidth-1:0] c);
        digit_t d;
        d.valid = c inside {[CH_ZERO:CH_NINE]};
        d.value = 4'(c - CH_ZERO);
        return d;
    endfunction

endpackage

// ----- hw/rtl/text_to_integer_parser_core.sv -----
// Text-to-integer parser top level: character stream in, parse results out.
// Depends on t2i_pkg and text_to_integer_parser_core_macros.svh.
//
// Input words on s_axis carry one character each from a stream of strings
// ended by a zero byte. A string starting with 0x or 0X is read as hex with
// one to eight digits; any other string is decimal with up to ten digits,
// optionally ended by k/K or m/M, which shift the value left by 10 or 20.
// Once a string is decided, one output word is sent on m_axis with the ok
// flag in tuser and the value in tdata (zero when ok is low). Characters
// after that point are dropped up to and including the terminator.
// Each character is handled combinationally; its result is registered in the
// output register, or in the skid register while the receiver stalls. One
// character per clock is sustained while s_axis_tready is high.
// An output register and a skid register separate the two sides, so
// s_axis_tready depends only on registered state and drops only once both
// hold a word that the receiver has not yet taken.
// Reset clears the parse state and empties both output registers.
`include "text_to_integer_parser_core_macros.svh"

module text_to_integer_parser_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value
    output logic [0:0]  m_axis_tuser    // [0] ok
);

    localparam int unsigned VW = t2i_pkg::ValueWidth;
    localparam int unsigned PW = t2i_pkg::PosWidth;

    logic [PW-1:0]  position_reg, position_next;
    logic           hex_mode_reg, hex_mode_next;
    logic           first_was_zero_reg, first_was_zero_next;
    logic [VW-1:0]  accumulator_reg, accumulator_next;
    logic           skipping_reg, skipping_next;

    logic             out_valid_reg, out_valid_next;
    t2i_pkg::result_t out_data_reg, out_data_next;
    logic             skid_valid_reg, skid_valid_next;
    t2i_pkg::result_t skid_data_reg, skid_data_next;

    logic             accept;
    logic             emit;
    t2i_pkg::result_t result;
    t2i_pkg::digit_t  hex_d;
    t2i_pkg::digit_t  dec_d;
    logic [7:0]       ch;
    logic [VW-1:0]    dec_acc;
    logic [VW-1:0]    hex_acc;

    assign ch            = s_axis_tdata;
    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign hex_d         = t2i_pkg::hex_digit(ch);
    assign dec_d         = t2i_pkg::dec_digit(ch);
    assign dec_acc       = {accumulator_reg[VW-4:0], 3'b000} + {accumulator_reg[VW-2:0], 1'b0}
                           + {{(VW-4){1'b0}}, dec_d.value};
    assign hex_acc       = {accumulator_reg[VW-1-t2i_pkg::HexShift:0], hex_d.value};

    always_comb
    begin
        position_next       = position_reg;
        hex_mode_next       = hex_mode_reg;
        first_was_zero_next = first_was_zero_reg;
        accumulator_next    = accumulator_reg;
        skipping_next       = skipping_reg;
        emit                = 1'b0;
        result.ok           = 1'b0;
        result.value        = '0;

        if (skipping_reg) begin
            if (ch == t2i_pkg::CH_NUL) begin
                skipping_next = 1'b0;
            end
        end else if (ch == t2i_pkg::CH_NUL) begin
            emit                = 1'b1;
            result.ok           = !(hex_mode_reg && position_reg == t2i_pkg::HexFirstDigitIndex);
            result.value        = result.ok ? accumulator_reg : '0;
            position_next       = '0;
            hex_mode_next       = 1'b0;
            first_was_zero_next = 1'b0;
            accumulator_next    = '0;
        end else if (hex_mode_reg) begin
            if (position_reg >= t2i_pkg::DigitLimitIndex || !hex_d.valid) begin
                emit          = 1'b1;
                skipping_next = 1'b1;
            end else begin
                accumulator_next = hex_acc;
                position_next    = position_reg + 1'b1;
            end
        end else if (position_reg == PW'(1) && first_was_zero_reg
                     && (ch == t2i_pkg::CH_LOWER_X || ch == t2i_pkg::CH_UPPER_X)) begin
            hex_mode_next = 1'b1;
            position_next = t2i_pkg::HexFirstDigitIndex;
        end else if (position_reg != '0
                     && (ch == t2i_pkg::CH_LOWER_K || ch == t2i_pkg::CH_UPPER_K)) begin
            emit          = 1'b1;
            result.ok     = 1'b1;
            result.value  = accumulator_reg << t2i_pkg::KiloShift;
            skipping_next = 1'b1;
        end else if (position_reg != '0
                     && (ch == t2i_pkg::CH_LOWER_M || ch == t2i_pkg::CH_UPPER_M)) begin
            emit          = 1'b1;
            result.ok     = 1'b1;
            result.value  = accumulator_reg << t2i_pkg::MegaShift;
            skipping_next = 1'b1;
        end else if (dec_d.valid && position_reg < t2i_pkg::DigitLimitIndex) begin
            accumulator_next = dec_acc;
            if (position_reg == '0) begin
                first_was_zero_next = (ch == t2i_pkg::CH_ZERO);
            end
            position_next = position_reg + 1'b1;
        end else begin
            emit          = 1'b1;
            skipping_next = 1'b1;
        end

        // Every decided string leaves the parse state cleared while skipping.
        if (skipping_next && !skipping_reg) begin
            position_next       = '0;
            hex_mode_next       = 1'b0;
            first_was_zero_next = 1'b0;
            accumulator_next    = '0;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (!out_valid_reg || m_axis_tready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = accept && emit;
                out_data_next  = result;
            end
        end else if (accept && emit) begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            position_reg       <= '0;
            hex_mode_reg       <= 1'b0;
            first_was_zero_reg <= 1'b0;
            accumulator_reg    <= '0;
            skipping_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            skid_valid_reg     <= 1'b0;
        end else begin
            if (accept) begin
                position_reg       <= position_next;
                hex_mode_reg       <= hex_mode_next;
                first_was_zero_reg <= first_was_zero_next;
                accumulator_reg    <= accumulator_next;
                skipping_reg       <= skipping_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg.value;
    assign m_axis_tuser[0] = out_data_reg.ok;

    `T2I_ASSERT_IMP(a_skid_implies_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `T2I_ASSERT_IMP(a_fail_value_zero, clk, rst_n, out_valid_reg && !out_data_reg.ok,
                    out_data_reg.value == '0)
    `T2I_ASSERT_IMP(a_position_range, clk, rst_n, 1'b1,
                    position_reg <= t2i_pkg::DigitLimitIndex)
    `T2I_ASSERT_IMP(a_skip_cleared, clk, rst_n, skipping_reg,
                    position_reg == '0 && !hex_mode_reg && accumulator_reg == '0)
    `T2I_ASSERT_NXT(a_skid_drains, clk, rst_n, skid_valid_reg && m_axis_tready,
                    out_valid_reg && !skid_valid_reg)

endmodule
